### src/cs9_pkg.sv
package cs9_pkg;

  localparam int MAX_FACE_EDGE = 64;
  localparam int ACC_BITS      = 48;

  localparam int NUM_W  = 48;
  localparam int DEN_W  = 32;
  localparam int SQRT_W = 36;
  localparam int DIV_STEPS  = NUM_W;
  localparam int SQRT_STEPS = SQRT_W / 2;

  typedef enum logic [1:0] {
    OP_DIV  = 2'b01,
    OP_SQRT = 2'b10
  } iter_op_t;

  typedef struct packed {
    logic             start;
    iter_op_t         op;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } iter_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] result;
  } iter_rsp_t;

  typedef logic [16:0] lin_tab_t [256];

  // sRGB to linear, Q1.16; 12th power against a 5th-power search
  function automatic logic [16:0] srgb_entry(input int unsigned v);
    longint unsigned t, t2, t4, t8, p, lo, hi, mid, yy, y2, y4, y5, vv;
    vv = longint'(v);
    lo = 0;
    hi = 131072;
    if (v <= 10) begin
      return 17'((vv * 6553600 + 164730) / 329460);
    end
    t  = ((vv * 1000 + 14025) << 30) / 269025;
    t2 = (t * t) >> 30;
    t4 = (t2 * t2) >> 30;
    t8 = (t4 * t4) >> 30;
    p  = (t8 * t4) >> 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      yy  = mid << 13;
      y2  = (yy * yy) >> 30;
      y4  = (y2 * y2) >> 30;
      y5  = (y4 * yy) >> 30;
      if (y5 <= p) lo = mid;
      else hi = mid - 1;
    end
    return 17'((lo + 1) >> 1);
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    for (int v = 0; v < 256; v++) begin
      tab[v] = srgb_entry(v);
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

  localparam logic [16:0] BASIS_K [9] = '{
    17'd18487, 17'd32021, 17'd32021, 17'd32021, 17'd71601,
    17'd71601, 17'd20670, 17'd71601, 17'd35801
  };

  // round half away from zero, divide by 2^16
  function automatic logic signed [51:0] rnd16(input logic signed [67:0] v);
    logic signed [67:0] t;
    t = v + (v[67] ? 68'sd32767 : 68'sd32768);
    return t[67:16];
  endfunction

endpackage

### src/cubemap_sh9_projection.sv
// Order-2 spherical-harmonic projection of a cubemap, one texel per request.
// cfg channel: cfg_data is the face edge in texels (0 reads as 1, above 64
//   as 64); always ready, to be written only while the block is idle.
// s_axis: one texel per request. The block takes a texel only when it has
//   finished the last one; each texel runs through the shared divide/
//   square-root unit (four 48-step divides and two 18-step roots) and
//   through a chain of multiplier passes.
// m_axis: on a texel with tlast set, after its own work, 27 coefficients
//   leave in order blue, green, red, nine each, one per cycle while the
//   receiver takes them; tlast marks the 27th. Accumulators are cleared as
//   each coefficient is sent.
// A single output register parts the two sides; a stalled receiver holds
//   the read-out and, through it, the next texel.
// Reset: accumulators cleared, face edge back to 16, output empty.
module cubemap_sh9_projection (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // face_sel[2:0], row_pos[8:3], col_pos[14:9], blue_byte[22:15],
  // green_byte[30:23], red_byte[38:31], zero [39]
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // coeff_value[31:0]
  output logic [31:0] m_axis_tdata,
  // color_channel[1:0], coeff_index[5:2], zero [7:6]
  output logic [7:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import cs9_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_FI   = 15'b000000000000010,
    ST_FJ   = 15'b000000000000100,
    ST_SQS  = 15'b000000000001000,
    ST_D16  = 15'b000000000010000,
    ST_INV  = 15'b000000000100000,
    ST_R16  = 15'b000000001000000,
    ST_D15  = 15'b000000010000000,
    ST_W    = 15'b000000100000000,
    ST_DIR  = 15'b000001000000000,
    ST_BAS  = 15'b000010000000000,
    ST_CST  = 15'b000100000000000,
    ST_LIN  = 15'b001000000000000,
    ST_ACC  = 15'b010000000000000,
    ST_EMIT = 15'b100000000000000
  } state_t;

  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_LAST = 3'd5;
  localparam logic [1:0] CH_LAST = 2'd2;
  localparam logic [3:0] K_LAST  = 4'd8;
  localparam int         N_COEF  = 27;

  state_t state;
  logic [6:0] face_edge;
  logic [6:0] e_eff;
  logic [6:0] e_max;

  logic [2:0]  face;
  logic [5:0]  pos_i;
  logic [5:0]  pos_j;
  logic [7:0]  rgb [3];
  logic        fin;

  logic        issued;
  logic [4:0]  cnt;
  logic [4:0]  wi;
  logic [1:0]  ich;
  logic [3:0]  ik;

  logic signed [17:0] fi;
  logic signed [17:0] fj;
  logic [33:0]        s;
  logic [16:0]        d16;
  logic [16:0]        inv;
  logic [16:0]        r16;
  logic [17:0]        d15;
  logic [30:0]        den;
  logic [31:0]        w;
  logic signed [17:0] dir [3];
  logic signed [17:0] p [6];
  logic signed [19:0] bv [9];
  logic [32:0]        cc [3];
  logic signed [ACC_BITS-1:0] acc [N_COEF];

  logic signed [17:0] sv [3];
  logic signed [19:0] braw [9];
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] prod;

  iter_req_t req;
  iter_rsp_t rsp;

  logic [5:0] row_c;
  logic [5:0] col_c;

  cs9_iter_unit u_iter (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  function automatic logic signed [ACC_BITS-1:0] acc_sat(
    input logic signed [ACC_BITS-1:0] a,
    input logic signed [51:0]         inc
  );
    logic signed [ACC_BITS:0] sum;
    sum = (ACC_BITS+1)'(a) + (ACC_BITS+1)'(inc);
    if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
      return sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end
    return sum[ACC_BITS-1:0];
  endfunction

  function automatic logic [31:0] out_val(input logic signed [ACC_BITS-1:0] a);
    logic signed [ACC_BITS:0] t;
    logic signed [63:0]       r;
    t = (ACC_BITS+1)'(a) + (ACC_BITS+1)'(a[ACC_BITS-1] ? 31 : 32);
    r = 64'($signed(t[ACC_BITS:6]));
    if (r > 64'sd2147483647) return 32'h7FFFFFFF;
    if (r < -64'sd2147483648) return 32'h80000000;
    return r[31:0];
  endfunction

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    if (face_edge == 7'd0) e_eff = 7'd1;
    else if (face_edge > 7'(MAX_FACE_EDGE)) e_eff = 7'(MAX_FACE_EDGE);
    else e_eff = face_edge;
    e_max = e_eff - 7'd1;
    row_c = (7'(s_axis_tdata[8:3]) > e_max) ? e_max[5:0] : s_axis_tdata[8:3];
    col_c = (7'(s_axis_tdata[14:9]) > e_max) ? e_max[5:0] : s_axis_tdata[14:9];
  end

  always_comb begin
    unique case (face)
      FACE_PX: begin sv[0] = 18'sd65536;  sv[1] = -fi; sv[2] = -fj; end
      FACE_NX: begin sv[0] = -18'sd65536; sv[1] = -fi; sv[2] = fj;  end
      FACE_PY: begin sv[0] = fj; sv[1] = 18'sd65536;  sv[2] = fi;  end
      FACE_NY: begin sv[0] = fj; sv[1] = -18'sd65536; sv[2] = -fi; end
      FACE_PZ: begin sv[0] = fj; sv[1] = -fi; sv[2] = 18'sd65536;  end
      default: begin sv[0] = -fj; sv[1] = -fi; sv[2] = -18'sd65536; end
    endcase
  end

  always_comb begin
    braw[0] = 20'sd65536;
    braw[1] = 20'(dir[1]);
    braw[2] = 20'(dir[2]);
    braw[3] = 20'(dir[0]);
    braw[4] = 20'(p[0]);
    braw[5] = 20'(p[1]);
    braw[6] = 20'(p[2]) + 20'(p[2]) + 20'(p[2]) - 20'sd65536;
    braw[7] = 20'(p[3]);
    braw[8] = 20'(p[4]) - 20'(p[5]);
  end

  assign wi = cnt - 5'd1;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SQS: begin
        if (cnt == 5'd0) begin mul_a = 34'(fi); mul_b = 34'(fi); end
        else begin mul_a = 34'(fj); mul_b = 34'(fj); end
      end
      ST_D15: begin
        priority case (cnt)
          5'd0:    begin mul_a = 34'(d16);   mul_b = 34'(r16); end
          5'd1:    begin mul_a = 34'(e_eff); mul_b = 34'(e_eff); end
          default: begin mul_a = 34'(prod[12:0]); mul_b = 34'(d15); end
        endcase
      end
      ST_DIR: begin
        if (cnt < 5'd3) begin mul_a = 34'(sv[cnt[1:0]]); mul_b = 34'(inv); end
      end
      ST_BAS: begin
        priority case (cnt)
          5'd0:    begin mul_a = 34'(dir[0]); mul_b = 34'(dir[1]); end
          5'd1:    begin mul_a = 34'(dir[1]); mul_b = 34'(dir[2]); end
          5'd2:    begin mul_a = 34'(dir[2]); mul_b = 34'(dir[2]); end
          5'd3:    begin mul_a = 34'(dir[0]); mul_b = 34'(dir[2]); end
          5'd4:    begin mul_a = 34'(dir[0]); mul_b = 34'(dir[0]); end
          5'd5:    begin mul_a = 34'(dir[1]); mul_b = 34'(dir[1]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_CST: begin
        if (cnt < 5'd9) begin
          mul_a = 34'(braw[cnt[3:0]]);
          mul_b = 34'(BASIS_K[cnt[3:0]]);
        end
      end
      ST_LIN: begin
        if (cnt < 5'd3) begin
          mul_a = 34'(LIN_TAB[rgb[cnt[1:0]]]);
          mul_b = 34'(w);
        end
      end
      ST_ACC: begin
        if (cnt < 5'(N_COEF)) begin mul_a = 34'(cc[ich]); mul_b = 34'(bv[ik]); end
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    req.start = 1'b0;
    req.op    = OP_DIV;
    req.num   = '0;
    req.den   = '0;
    unique case (state)
      ST_FI:  begin
        req.start = !issued;
        req.num   = {25'b0, pos_i, 17'b0};
        req.den   = {25'b0, e_eff};
      end
      ST_FJ:  begin
        req.start = !issued;
        req.num   = {25'b0, pos_j, 17'b0};
        req.den   = {25'b0, e_eff};
      end
      ST_D16: begin
        req.start = !issued;
        req.op    = OP_SQRT;
        req.num   = {14'b0, s};
      end
      ST_INV: begin
        req.start = !issued;
        req.num   = 48'h0001_0000_0000;
        req.den   = {15'b0, d16};
      end
      ST_R16: begin
        req.start = !issued;
        req.op    = OP_SQRT;
        req.num   = {15'b0, d16, 16'b0};
      end
      ST_W:   begin
        req.start = !issued;
        req.num   = 48'hB000_0000_0000;
        req.den   = {1'b0, den};
      end
      default: req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      face_edge     <= 7'd16;
      issued        <= 1'b0;
      cnt           <= '0;
      ich           <= '0;
      ik            <= '0;
      m_axis_tvalid <= 1'b0;
      for (int n = 0; n < N_COEF; n++) acc[n] <= '0;
    end else begin
      if (cfg_valid) face_edge <= cfg_data;
      if (req.start) issued <= 1'b1;
      if (m_axis_tready && state != ST_EMIT) m_axis_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          ich <= '0;
          ik  <= '0;
          if (s_axis_tvalid) begin
            face   <= s_axis_tdata[2:0];
            pos_i  <= row_c;
            pos_j  <= col_c;
            rgb[0] <= s_axis_tdata[22:15];
            rgb[1] <= s_axis_tdata[30:23];
            rgb[2] <= s_axis_tdata[38:31];
            fin    <= s_axis_tlast;
            if (s_axis_tdata[2:0] > FACE_LAST) state <= s_axis_tlast ? ST_EMIT : ST_IDLE;
            else state <= ST_FI;
          end
        end
        ST_FI: if (rsp.done) begin
          fi     <= $signed({1'b0, rsp.result[16:0]}) - 18'sd65536;
          issued <= 1'b0;
          state  <= ST_FJ;
        end
        ST_FJ: if (rsp.done) begin
          fj     <= $signed({1'b0, rsp.result[16:0]}) - 18'sd65536;
          issued <= 1'b0;
          cnt    <= '0;
          state  <= ST_SQS;
        end
        ST_SQS: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd1) s <= 34'h1_0000_0000 + 34'(prod[32:0]);
          if (cnt == 5'd2) begin
            s     <= s + 34'(prod[32:0]);
            state <= ST_D16;
          end
        end
        ST_D16: if (rsp.done) begin
          d16    <= rsp.result[16:0];
          issued <= 1'b0;
          state  <= ST_INV;
        end
        ST_INV: if (rsp.done) begin
          inv    <= rsp.result[16:0];
          issued <= 1'b0;
          state  <= ST_R16;
        end
        ST_R16: if (rsp.done) begin
          r16    <= rsp.result[16:0];
          issued <= 1'b0;
          cnt    <= '0;
          state  <= ST_D15;
        end
        ST_D15: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd1) d15 <= prod[33:16];
          if (cnt == 5'd3) begin
            den   <= prod[30:0];
            state <= ST_W;
          end
        end
        ST_W: if (rsp.done) begin
          w      <= rsp.result[31:0];
          issued <= 1'b0;
          cnt    <= '0;
          state  <= ST_DIR;
        end
        ST_DIR: begin
          if (cnt != 5'd0) dir[wi[1:0]] <= 18'(rnd16(prod));
          if (cnt == 5'd3) begin
            cnt   <= '0;
            state <= ST_BAS;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_BAS: begin
          if (cnt != 5'd0) p[wi[2:0]] <= 18'(rnd16(prod));
          if (cnt == 5'd6) begin
            cnt   <= '0;
            state <= ST_CST;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_CST: begin
          if (cnt != 5'd0) bv[wi[3:0]] <= 20'(rnd16(prod));
          if (cnt == 5'd9) begin
            cnt   <= '0;
            state <= ST_LIN;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_LIN: begin
          if (cnt != 5'd0) cc[wi[1:0]] <= prod[48:16];
          if (cnt == 5'd3) begin
            cnt   <= '0;
            ich   <= '0;
            ik    <= '0;
            state <= ST_ACC;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_ACC: begin
          if (cnt != 5'd0) acc[wi] <= acc_sat(acc[wi], rnd16(prod));
          if (cnt == 5'(N_COEF)) begin
            cnt   <= '0;
            ich   <= '0;
            ik    <= '0;
            state <= fin ? ST_EMIT : ST_IDLE;
          end else begin
            cnt <= cnt + 5'd1;
            if (ik == K_LAST) begin
              ik  <= '0;
              ich <= ich + 2'd1;
            end else begin
              ik <= ik + 4'd1;
            end
          end
        end
        ST_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= out_val(acc[cnt]);
            m_axis_tuser  <= {2'b00, ik, ich};
            m_axis_tlast  <= (cnt == 5'(N_COEF - 1));
            acc[cnt]      <= '0;
            cnt           <= cnt + 5'd1;
            if (ik == K_LAST) begin
              ik  <= '0;
              ich <= ich + 2'd1;
            end else begin
              ik <= ik + 4'd1;
            end
            if (cnt == 5'(N_COEF - 1)) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (state == ST_IDLE))
    else $error("texel taken while busy");

  a_last_coeff: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[5:2] == K_LAST && m_axis_tuser[1:0] == CH_LAST))
    else $error("run end not on last red coefficient");

  a_face_start: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[2:0] <= FACE_LAST) |=> (state == ST_FI))
    else $error("valid face did not start work");

  a_emit_fin: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> fin)
    else $error("read-out without final texel");

  a_unit_done: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> issued)
    else $error("unit result without request");

endmodule

### src/cs9_iter_unit.sv
module cs9_iter_unit (
  input  logic                clk,
  input  logic                rst,
  input  cs9_pkg::iter_req_t  req,
  output cs9_pkg::iter_rsp_t  rsp
);
  import cs9_pkg::*;

  logic             busy;
  logic             done;
  iter_op_t         op;
  logic [5:0]       cnt;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;

  logic [DEN_W:0]   r2;
  logic             div_ge;
  logic [21:0]      r4;
  logic [21:0]      trial;
  logic             sqrt_ge;
  logic             bit_in;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    r2      = {rem, num[NUM_W-1]};
    div_ge  = r2 >= {1'b0, den};
    r4      = {rem[19:0], num[NUM_W-1 -: 2]};
    trial   = {2'b00, quo[17:0], 2'b01};
    sqrt_ge = r4 >= trial;
    if (op == OP_SQRT) begin
      bit_in   = sqrt_ge;
      rem_next = sqrt_ge ? DEN_W'(r4 - trial) : DEN_W'(r4);
    end else begin
      bit_in   = div_ge;
      rem_next = div_ge ? DEN_W'(r2 - {1'b0, den}) : DEN_W'(r2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        num  <= (req.op == OP_SQRT) ? (req.num << (NUM_W - SQRT_W)) : req.num;
        den  <= req.den;
        rem  <= '0;
        quo  <= '0;
        cnt  <= (req.op == OP_SQRT) ? 6'(SQRT_STEPS - 1) : 6'(DIV_STEPS - 1);
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[NUM_W-2:0], bit_in};
        num <= (op == OP_SQRT) ? (num << 2) : (num << 1);
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = quo;

endmodule

### tb/sv/tb_cubemap_sh9_projection.sv
module tb_cubemap_sh9_projection;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 8000;
  localparam int SETTLE       = 600;
  localparam int HOLD_CYCLES  = 3000;
  localparam int ACC_MAX_EDGE = 64;

  localparam logic [2:0] FACE_PX = 3'd0, FACE_NX = 3'd1, FACE_PY = 3'd2,
                         FACE_NY = 3'd3, FACE_PZ = 3'd4, FACE_NZ = 3'd5,
                         FACE_NONE6 = 3'd6, FACE_NONE7 = 3'd7;

  localparam longint SH_K [9] = '{18487, 32021, 32021, 32021, 71601,
                                  71601, 20670, 71601, 35801};

  typedef struct packed {
    logic [2:0] face;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       fin;
    logic       zero_exp;
  } texel_t;

  typedef struct packed {
    logic [1:0]  ch;
    logic [3:0]  idx;
    logic [31:0] val;
    logic        last;
  } coeff_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [7:0]  m_axis_tuser;
  logic        m_axis_tlast;

  cubemap_sh9_projection dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model state
  longint unsigned lin_lut [256];
  logic [6:0]      edge_reg;
  longint          sh_acc [27];
  coeff_t          coeff_q [$];

  int  mismatches = 0;
  int  n_texels = 0;
  int  n_finals = 0;
  int  n_coeffs = 0;
  int  n_sat = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  bit  any_fire;

  function automatic longint unsigned q30mul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint unsigned srgb_to_lin(int unsigned v);
    longint unsigned t, t4, p, lo, hi, mid, y, y4;
    if (v <= 10) return (longint'(v) * 6553600 + 164730) / 329460;
    t  = ((longint'(v) * 1000 + 14025) << 30) / 269025;
    t4 = q30mul(q30mul(t, t), q30mul(t, t));
    p  = q30mul(q30mul(t4, t4), t4);
    lo = 0;
    hi = 131072;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      y   = mid << 13;
      y4  = q30mul(q30mul(y, y), q30mul(y, y));
      if (q30mul(y4, y) <= p) lo = mid;
      else hi = mid - 1;
    end
    return (lo + 1) >> 1;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint rnd_sh(longint v, int n);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 << (n - 1))) >>> n;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint unsigned eff_edge();
    if (edge_reg == 0) return 1;
    if (edge_reg > ACC_MAX_EDGE) return ACC_MAX_EDGE;
    return edge_reg;
  endfunction

  task automatic project_texel(texel_t t);
    longint unsigned e, i, j, s, d16, inv, r16, d15, w, lin;
    longint fi, fj, sx, sy, sz, x, y, z, c, sum;
    longint b [9];
    longint mx;
    mx = (64'sd1 <<< 47) - 1;
    if (t.face > FACE_NZ) return;
    e = eff_edge();
    i = (t.row > e - 1) ? e - 1 : t.row;
    j = (t.col > e - 1) ? e - 1 : t.col;
    fi = longint'((2 * i * 65536) / e) - 65536;
    fj = longint'((2 * j * 65536) / e) - 65536;
    s   = (64'd1 << 32) + longint'(fi * fi) + longint'(fj * fj);
    d16 = int_sqrt(s);
    inv = (64'd1 << 32) / d16;
    r16 = int_sqrt(d16 << 16);
    d15 = (d16 * r16) >> 16;
    w   = (64'd11 << 44) / (e * e * d15);
    case (t.face)
      FACE_PX: begin sx = 65536;  sy = -fi;    sz = -fj;    end
      FACE_NX: begin sx = -65536; sy = -fi;    sz = fj;     end
      FACE_PY: begin sx = fj;     sy = 65536;  sz = fi;     end
      FACE_NY: begin sx = fj;     sy = -65536; sz = -fi;    end
      FACE_PZ: begin sx = fj;     sy = -fi;    sz = 65536;  end
      default: begin sx = -fj;    sy = -fi;    sz = -65536; end
    endcase
    x = rnd_sh(sx * longint'(inv), 16);
    y = rnd_sh(sy * longint'(inv), 16);
    z = rnd_sh(sz * longint'(inv), 16);
    b[0] = 65536;
    b[1] = y;
    b[2] = z;
    b[3] = x;
    b[4] = rnd_sh(x * y, 16);
    b[5] = rnd_sh(y * z, 16);
    b[6] = 3 * rnd_sh(z * z, 16) - 65536;
    b[7] = rnd_sh(x * z, 16);
    b[8] = rnd_sh(x * x, 16) - rnd_sh(y * y, 16);
    for (int k = 0; k < 9; k++) b[k] = rnd_sh(b[k] * SH_K[k], 16);
    for (int ch = 0; ch < 3; ch++) begin
      lin = lin_lut[(ch == 0) ? t.blue : (ch == 1) ? t.green : t.red];
      c = longint'((lin * w) >> 16);
      for (int k = 0; k < 9; k++) begin
        sum = sh_acc[ch*9+k] + rnd_sh(c * b[k], 16);
        if (sum > mx) sum = mx;
        if (sum < -mx - 1) sum = -mx - 1;
        sh_acc[ch*9+k] = sum;
      end
    end
  endtask

  task automatic emit_coeffs(bit force_zero);
    coeff_t r;
    longint v;
    for (int n = 0; n < 27; n++) begin
      v = rnd_sh(sh_acc[n], 6);
      if (v > 64'sd2147483647) begin v = 64'sd2147483647; n_sat++; end
      if (v < -64'sd2147483648) begin v = -64'sd2147483648; n_sat++; end
      r.ch   = 2'(n / 9);
      r.idx  = 4'(n % 9);
      r.val  = force_zero ? 32'd0 : v[31:0];
      r.last = (n == 26);
      coeff_q.push_back(r);
      sh_acc[n] = 0;
    end
  endtask

  task automatic send_texel(texel_t t);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, t.red, t.green, t.blue, t.col, t.row, t.face};
    s_axis_tlast  <= t.fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_texels++;
    project_texel(t);
    if (t.fin) begin
      n_finals++;
      emit_coeffs(t.zero_exp);
    end
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (coeff_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_edge(logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    edge_reg = v;
  endtask

  // receiver: random stalls, one long hold-off on request, result check
  int rx_wait = 0;
  always @(posedge clk) begin
    coeff_t exp_c;
    if (m_axis_tvalid && m_axis_tready) begin
      n_coeffs++;
      if (coeff_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected coefficient ch=%0d idx=%0d val=%h",
                   m_axis_tuser[1:0], m_axis_tuser[5:2], m_axis_tdata);
      end else begin
        exp_c = coeff_q.pop_front();
        if (m_axis_tuser[1:0] !== exp_c.ch || m_axis_tuser[5:2] !== exp_c.idx ||
            m_axis_tdata !== exp_c.val || m_axis_tlast !== exp_c.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("coeff mismatch: exp ch=%0d idx=%0d val=%h last=%b, got ch=%0d idx=%0d val=%h last=%b",
                     exp_c.ch, exp_c.idx, exp_c.val, exp_c.last, m_axis_tuser[1:0],
                     m_axis_tuser[5:2], m_axis_tdata, m_axis_tlast);
        end
      end
      rx_wait = quiet ? 0 : $urandom_range(0, 8);
    end
    if (hold_req && m_axis_tvalid) begin
      hold_req = 1'b0;
      rx_wait = HOLD_CYCLES;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      m_axis_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    any_fire = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
               (cfg_valid && cfg_ready);
    idle_cycles = (rst || any_fire) ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request accepted for %0d cycles", STALL_LIMIT);
      $display("** cubemap_sh9_projection: FAILED **");
      $finish;
    end
  end

  texel_t dir_tab [13] = '{
    '{FACE_NONE6, 0,  0,  255, 255, 255, 1, 1},
    '{FACE_NONE7, 63, 63, 255, 255, 255, 1, 1},
    '{FACE_PX,    0,  0,  0,   10,  11,  0, 0},
    '{FACE_NX,    63, 63, 255, 254, 12,  0, 0},
    '{FACE_PY,    15, 0,  128, 64,  32,  0, 0},
    '{FACE_NY,    0,  15, 1,   2,   3,   0, 0},
    '{FACE_PZ,    7,  8,  200, 100, 50,  0, 0},
    '{FACE_NZ,    63, 0,  255, 0,   255, 0, 0},
    '{FACE_PX,    8,  8,  255, 255, 255, 0, 0},
    '{FACE_NONE6, 5,  5,  255, 255, 255, 0, 0},
    '{FACE_NZ,    1,  2,  9,   99,  199, 1, 0},
    '{FACE_PZ,    0,  0,  255, 255, 255, 1, 0},
    '{FACE_NONE7, 0,  0,  0,   0,   0,   1, 1}
  };

  logic [6:0] edge_plan [7] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd7, 7'd33, 7'd2};

  initial begin
    texel_t t;
    int lim;
    for (int v = 0; v < 256; v++) lin_lut[v] = srgb_to_lin(v);
    edge_reg = 7'd16;
    for (int n = 0; n < 27; n++) sh_acc[n] = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[k]) send_texel(dir_tab[k]);

    for (int p = 0; p < 7; p++) begin
      drain_and_settle();
      write_edge(edge_plan[p]);
      quiet = (p % 3 == 2);
      if (p == 1) hold_req = 1'b1;
      lim = (edge_plan[p] == 0) ? 1 : (edge_plan[p] > 64) ? 64 : edge_plan[p];
      for (int k = 0; k < 40; k++) begin
        t.face  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
        t.row   = $urandom_range(0, 1) ? 6'($urandom_range(0, lim - 1))
                                       : 6'($urandom_range(0, 63));
        t.col   = $urandom_range(0, 1) ? 6'($urandom_range(0, lim - 1))
                                       : 6'($urandom_range(0, 63));
        t.blue  = 8'($urandom_range(0, 255));
        t.green = 8'($urandom_range(0, 255));
        t.red   = 8'($urandom_range(0, 255));
        t.fin   = (k == 39) || ($urandom_range(0, 11) == 0);
        t.zero_exp = 1'b0;
        send_texel(t);
      end
    end

    drain_and_settle();
    write_edge(7'd16);

    $display("texels sent %0d, cubemaps closed %0d, coefficients checked %0d",
             n_texels, n_finals, n_coeffs);
    $display("face edges 16,1,64,0,127,7,33,2 covered; saturated outputs %0d", n_sat);
    if (mismatches == 0 && coeff_q.size() == 0) begin
      $display("** cubemap_sh9_projection: PASSED **");
    end else begin
      $display("mismatches %0d, outstanding %0d", mismatches, coeff_q.size());
      $display("** cubemap_sh9_projection: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
src/cs9_pkg.sv
src/cs9_iter_unit.sv
src/cubemap_sh9_projection.sv
tb/sv/tb_cubemap_sh9_projection.sv
